// ----- hw/rtl/pen_pkg.sv -----
// Shared types and constants for the polygon edge normal block.
// Depends on nothing; every other file refers to it by scoped names.
package pen_pkg;

  localparam int COORD_WIDTH      = 24;
  localparam int NORMAL_FRAC_DEF  = 14;
  localparam int CFG_W            = 50;
  localparam int OUT_W            = 16;
  localparam logic [CFG_W-1:0] MIN_LEN2_RESET = CFG_W'(1);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic                          last_vertex;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic                    zero_edge;
    logic                    last_normal;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_CHECK,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } pen_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic sqrt_step;
  } unit_ctrl_t;

endpackage

// ----- hw/rtl/pen_norm_unit.sv -----
// One normal component: bit-serial divide of mag^2 * 2^(2F+2) by len^2,
// then a two-bit-per-cycle square root, giving the rounded magnitude.
// Depends on pen_pkg.
module pen_norm_unit #(
  parameter int NORMAL_FRAC_BITS = pen_pkg::NORMAL_FRAC_DEF
) (
  input  logic                                  clk,
  input  pen_pkg::unit_ctrl_t                   ctrl,
  input  logic [2*pen_pkg::COORD_WIDTH-1:0]     mag_sq,
  input  logic [2*pen_pkg::COORD_WIDTH:0]       len2,
  output logic [NORMAL_FRAC_BITS+1:0]           mag_out
);

  localparam int LEN_W = 2 * pen_pkg::COORD_WIDTH + 1;
  localparam int QP_W  = 2 * NORMAL_FRAC_BITS + 4;
  localparam int RT_W  = NORMAL_FRAC_BITS + 2;
  localparam int SR_W  = NORMAL_FRAC_BITS + 3;
  localparam int SH_W  = NORMAL_FRAC_BITS + 5;

  logic [LEN_W:0]   rem_r;
  logic [LEN_W-1:0] len_r;
  logic [QP_W-1:0]  quo_r;
  logic [SR_W-1:0]  srem_r;
  logic [RT_W-1:0]  root_r;

  logic             div_ge;
  logic [LEN_W:0]   div_sub;
  logic [SH_W-1:0]  sq_sh;
  logic [SH_W-1:0]  sq_trial;
  logic             sq_ge;
  logic [SH_W-1:0]  sq_sub;
  logic [RT_W:0]    root_inc;

  always_comb begin
    div_ge   = rem_r >= {1'b0, len_r};
    div_sub  = div_ge ? (rem_r - {1'b0, len_r}) : rem_r;
    sq_sh    = {srem_r, quo_r[QP_W-1 -: 2]};
    sq_trial = SH_W'({root_r, 2'b01});
    sq_ge    = sq_sh >= sq_trial;
    sq_sub   = sq_ge ? (sq_sh - sq_trial) : sq_sh;
    // add one to the root, then halve: the root halved, rounded half up
    root_inc = {1'b0, root_r} + (RT_W+1)'(1);
    mag_out  = root_inc[RT_W:1];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem_r  <= (LEN_W+1)'(mag_sq);
      len_r  <= len2;
      quo_r  <= '0;
      srem_r <= '0;
      root_r <= '0;
    end else if (ctrl.div_step) begin
      rem_r <= {div_sub[LEN_W-1:0], 1'b0};
      quo_r <= {quo_r[QP_W-2:0], div_ge};
    end else if (ctrl.sqrt_step) begin
      srem_r <= sq_sub[SR_W-1:0];
      root_r <= {root_r[RT_W-2:0], sq_ge};
      quo_r  <= {quo_r[QP_W-3:0], 2'b00};
    end
  end

endmodule

// ----- hw/rtl/polygon_edge_normals.sv -----
// Polygon edge unit normals, top level. Uses pen_pkg and pen_norm_unit.
// Holds the vertex state, the edge sequencer and the output register.
//
// Vertices arrive one per transaction; each edge (previous to current, and
// the closing edge from the marked vertex back to the first) yields one
// result transaction holding the unit normal (-dy, dx) in signed Q2.14,
// rounded to nearest with ties away from zero, or a zero normal with
// zero_edge set when dx*dx + dy*dy is zero or falls below cfg register
// min_edge_length_squared (reset 1). An edge of usable length runs through
// squaring, sum, threshold check, a bit-serial divide of
// 2*NORMAL_FRAC_BITS + 3 steps and a two-bit-per-cycle square root of
// NORMAL_FRAC_BITS + 2 steps, both components in parallel, then the load
// into the output register. An edge flagged as zero length skips the
// divide and the root. Either kind of edge waits for as long as a full
// output register stays stalled. An unmarked vertex opening a polygon starts
// no edge; a marked vertex inside a polygon yields its own edge and then the
// closing edge. The input is stalled while an edge is in flight; a finished
// result waits in the output register without holding up the next vertex.
module polygon_edge_normals #(
  parameter int NORMAL_FRAC_BITS = pen_pkg::NORMAL_FRAC_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  pen_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output pen_pkg::out_item_t         out_data,
  input  logic                       cfg_wr_en,
  input  logic [pen_pkg::CFG_W-1:0]  cfg_wr_data
);

  localparam int CW        = pen_pkg::COORD_WIDTH;
  localparam int DW        = CW + 1;
  localparam int SQ_W      = 2 * CW;
  localparam int LEN_W     = 2 * CW + 1;
  localparam int CMP_W     = (LEN_W > pen_pkg::CFG_W) ? LEN_W : pen_pkg::CFG_W;
  localparam int DIV_STEPS = 2 * NORMAL_FRAC_BITS + 3;
  localparam int SQRT_STEPS = NORMAL_FRAC_BITS + 2;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int MAG_W     = NORMAL_FRAC_BITS + 2;
  localparam int OW        = (MAG_W > pen_pkg::OUT_W) ? MAG_W : pen_pkg::OUT_W;

  pen_pkg::pen_state_t state_r, state_nxt;
  pen_pkg::unit_ctrl_t ctrl;

  logic signed [CW-1:0]  first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic                  have_first_r;
  logic [pen_pkg::CFG_W-1:0] min_len2_r;
  logic signed [DW-1:0]  cur_dx_r, cur_dy_r, pend_dx_r, pend_dy_r;
  logic                  cur_last_r, pend_r;
  logic [SQ_W-1:0]       sqx_r, sqy_r;
  logic [LEN_W-1:0]      len2_r;
  logic                  zero_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  out_valid_r;
  pen_pkg::out_item_t    out_r;

  logic                  in_acc, out_load, out_free;
  logic signed [DW-1:0]  ax_s, ay_s, first_eff_x, first_eff_y;
  logic signed [DW-1:0]  da_x, da_y, db_x, db_y;
  logic [CW-1:0]         mag_x, mag_y;
  logic [MAG_W-1:0]      tx, ty;
  logic [OW-1:0]         nx_val, ny_val;

  assign in_stall  = (state_r != pen_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  // edge differences for the incoming vertex
  always_comb begin
    first_eff_x = have_first_r ? DW'(first_x_r) : DW'(in_data.vertex_x);
    first_eff_y = have_first_r ? DW'(first_y_r) : DW'(in_data.vertex_y);
    da_x = DW'(in_data.vertex_x) - DW'(prev_x_r);
    da_y = DW'(in_data.vertex_y) - DW'(prev_y_r);
    db_x = first_eff_x - DW'(in_data.vertex_x);
    db_y = first_eff_y - DW'(in_data.vertex_y);
    // normal (-dy, dx): x magnitude from dy, y magnitude from dx
    ax_s  = cur_dy_r[DW-1] ? -cur_dy_r : cur_dy_r;
    ay_s  = cur_dx_r[DW-1] ? -cur_dx_r : cur_dx_r;
    mag_x = ax_s[CW-1:0];
    mag_y = ay_s[CW-1:0];
  end

  pen_norm_unit #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_norm_x (
    .clk     (clk),
    .ctrl    (ctrl),
    .mag_sq  (sqx_r),
    .len2    (len2_r),
    .mag_out (tx)
  );

  pen_norm_unit #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_norm_y (
    .clk     (clk),
    .ctrl    (ctrl),
    .mag_sq  (sqy_r),
    .len2    (len2_r),
    .mag_out (ty)
  );

  // apply signs: x negative when dy is positive, y negative when dx is
  always_comb begin
    nx_val = (!cur_dy_r[DW-1] && (cur_dy_r != '0)) ? -OW'(tx) : OW'(tx);
    ny_val = cur_dx_r[DW-1] ? -OW'(ty) : OW'(ty);
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    ctrl.load      = 1'b0;
    ctrl.div_step  = 1'b0;
    ctrl.sqrt_step = 1'b0;
    out_load       = 1'b0;
    case (state_r)
      pen_pkg::ST_IDLE: begin
        if (in_acc && (have_first_r || in_data.last_vertex)) begin
          state_nxt = pen_pkg::ST_SQUARE;
        end
      end
      pen_pkg::ST_SQUARE: begin
        state_nxt = pen_pkg::ST_SUM;
      end
      pen_pkg::ST_SUM: begin
        state_nxt = pen_pkg::ST_CHECK;
      end
      pen_pkg::ST_CHECK: begin
        ctrl.load = 1'b1;
        state_nxt = pen_pkg::ST_DIV;
      end
      pen_pkg::ST_DIV: begin
        if (zero_r) begin
          state_nxt = pen_pkg::ST_OUT;
        end else begin
          ctrl.div_step = 1'b1;
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            state_nxt = pen_pkg::ST_SQRT;
          end
        end
      end
      pen_pkg::ST_SQRT: begin
        ctrl.sqrt_step = 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          state_nxt = pen_pkg::ST_OUT;
        end
      end
      pen_pkg::ST_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = pend_r ? pen_pkg::ST_SQUARE : pen_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pen_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pen_pkg::ST_IDLE;
      have_first_r <= 1'b0;
      first_x_r    <= '0;
      first_y_r    <= '0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      min_len2_r   <= pen_pkg::MIN_LEN2_RESET;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        min_len2_r <= cfg_wr_data;
      end
      if (in_acc) begin
        prev_x_r <= in_data.vertex_x;
        prev_y_r <= in_data.vertex_y;
        if (!have_first_r) begin
          first_x_r <= in_data.vertex_x;
          first_y_r <= in_data.vertex_y;
        end
        have_first_r <= !in_data.last_vertex;
        // closing edge waits behind the open edge
        pend_r <= have_first_r && in_data.last_vertex;
      end else if (out_load) begin
        pend_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (ctrl.load || (state_r == pen_pkg::ST_DIV && state_nxt == pen_pkg::ST_SQRT)) begin
        cnt_r <= '0;
      end else if (ctrl.div_step || ctrl.sqrt_step) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (have_first_r) begin
        cur_dx_r   <= da_x;
        cur_dy_r   <= da_y;
        cur_last_r <= 1'b0;
      end else begin
        cur_dx_r   <= db_x;
        cur_dy_r   <= db_y;
        cur_last_r <= 1'b1;
      end
      pend_dx_r <= db_x;
      pend_dy_r <= db_y;
    end else if (out_load && pend_r) begin
      cur_dx_r   <= pend_dx_r;
      cur_dy_r   <= pend_dy_r;
      cur_last_r <= 1'b1;
    end
    if (state_r == pen_pkg::ST_SQUARE) begin
      sqx_r <= mag_x * mag_x;
      sqy_r <= mag_y * mag_y;
    end
    if (state_r == pen_pkg::ST_SUM) begin
      len2_r <= LEN_W'(sqx_r) + LEN_W'(sqy_r);
    end
    if (state_r == pen_pkg::ST_CHECK) begin
      zero_r <= (len2_r == '0) || (CMP_W'(len2_r) < CMP_W'(min_len2_r));
    end
    if (out_load) begin
      out_r.zero_edge   <= zero_r;
      out_r.last_normal <= cur_last_r;
      out_r.normal_x    <= zero_r ? '0 : nx_val[pen_pkg::OUT_W-1:0];
      out_r.normal_y    <= zero_r ? '0 : ny_val[pen_pkg::OUT_W-1:0];
    end
  end

endmodule
